[rtl/core/arle_pkg.sv]
// Shared types, constants and register indexes of the animation-RLE frame decoder.
package arle_pkg;

   localparam int ADDR_W      = 30;
   localparam int MAX_WIDTH   = 4096;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] CSR_SOURCE_IS_ARGB      = 2'd0;
   localparam logic [1:0] CSR_FRAME_WIDTH         = 2'd1;
   localparam logic [1:0] CSR_FRAME_HEIGHT        = 2'd2;
   localparam logic [1:0] CSR_OUT_BYTES_PER_PIXEL = 2'd3;

   localparam logic [12:0] WIDTH_RESET  = 13'd640;
   localparam logic [15:0] HEIGHT_RESET = 16'd480;
   localparam logic [2:0]  BPP_RESET    = 3'd3;
   localparam logic [2:0]  BPP_FOUR     = 3'd4;

   localparam logic [3:0] HDR_FLAGS_LO  = 4'd5;
   localparam logic [3:0] HDR_FIRST_HI  = 4'd6;
   localparam logic [3:0] HDR_FIRST_LO  = 4'd7;
   localparam logic [3:0] HDR_COUNT_HI  = 4'd10;
   localparam logic [3:0] HDR_COUNT_LO  = 4'd11;
   localparam logic [3:0] HDR_LAST_BYTE = 4'd13;
   localparam int         RANGE_FLAG_BIT = 3;

   localparam logic [7:0] SKIP_AGAIN_CODE = 8'h00;
   localparam logic [7:0] END_LINE_CODE   = 8'hFF;

   typedef enum logic [5:0] {
      PH_HEADER     = 6'b000001,
      PH_LINE_SKIP  = 6'b000010,
      PH_CODE       = 6'b000100,
      PH_EXTRA_SKIP = 6'b001000,
      PH_COLOR      = 6'b010000,
      PH_IDLE       = 6'b100000
   } phase_type;

   typedef enum logic [2:0] {
      CMD_START      = 3'd0,
      CMD_LINE_SKIP  = 3'd1,
      CMD_EXTRA_SKIP = 3'd2,
      CMD_END_LINE   = 3'd3,
      CMD_PIXEL      = 3'd4,
      CMD_FRAME_END  = 3'd5
   } cmd_kind_type;

   // One decoded action handed from the parser to the address unit.
   typedef struct packed {
      cmd_kind_type kind;
      logic [15:0]  value;   // first line, skip byte or pixel count
      logic [23:0]  color;   // red, green, blue from the top bits down
      logic         last;
   } cmd_type;

   typedef struct packed {
      logic        argb;
      logic [15:0] height;
      logic        stride4;
      logic [14:0] row_step;
   } cfg_type;

endpackage

[rtl/core/arle_front.sv]
// Byte parser: walks the header and line codes and issues address-unit commands.
module arle_front import arle_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       accept,
   input  logic [7:0] data_byte,
   input  logic       packet_end,
   output logic       push,
   output cmd_type    cmd
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  hdr_count_ff, hdr_count_in;
   logic        range_ff, range_in;
   logic [15:0] first_line_ff, first_line_in;
   logic [15:0] lines_ff, lines_in;
   logic [7:0]  run_ff, run_in;
   logic        fill_ff, fill_in;
   logic [1:0]  color_idx_ff, color_idx_in;
   logic [23:0] color_ff, color_in;

   logic [23:0] color_shift;
   logic [2:0]  color_next_idx;
   logic [2:0]  color_need;
   logic [15:0] lines_dec;
   logic        produced;

   always_comb begin
      phase_in      = phase_ff;
      hdr_count_in  = hdr_count_ff;
      range_in      = range_ff;
      first_line_in = first_line_ff;
      lines_in      = lines_ff;
      run_in        = run_ff;
      fill_in       = fill_ff;
      color_idx_in  = color_idx_ff;
      color_in      = color_ff;
      push          = 1'b0;
      produced      = 1'b0;
      cmd           = '{kind: CMD_FRAME_END, value: 16'd0, color: 24'd0, last: 1'b0};

      color_shift    = {color_ff[15:0], data_byte};
      color_next_idx = {1'b0, color_idx_ff} + 3'd1;
      color_need     = cfg.argb ? 3'd4 : 3'd3;
      lines_dec      = lines_ff - 16'd1;

      if (accept) begin
         case (phase_ff)
            PH_HEADER: begin
               if (hdr_count_ff == HDR_FLAGS_LO) range_in = data_byte[RANGE_FLAG_BIT];
               if (hdr_count_ff == HDR_FIRST_HI) first_line_in = {data_byte, 8'h00};
               if (hdr_count_ff == HDR_FIRST_LO) first_line_in = {first_line_ff[15:8], data_byte};
               if (hdr_count_ff == HDR_COUNT_HI) lines_in = {data_byte, 8'h00};
               if (hdr_count_ff == HDR_COUNT_LO) lines_in = {lines_ff[15:8], data_byte};
               if (hdr_count_ff == HDR_FLAGS_LO && !data_byte[RANGE_FLAG_BIT]) begin
                  // No line range in the header: decode the whole frame.
                  first_line_in = 16'd0;
                  lines_in      = cfg.height;
                  push          = 1'b1;
                  cmd.kind      = CMD_START;
                  cmd.value     = 16'd0;
                  phase_in      = (cfg.height == 16'd0) ? PH_IDLE : PH_LINE_SKIP;
               end else if (hdr_count_ff >= HDR_LAST_BYTE) begin
                  push      = 1'b1;
                  cmd.kind  = CMD_START;
                  cmd.value = first_line_ff;
                  phase_in  = (lines_ff == 16'd0) ? PH_IDLE : PH_LINE_SKIP;
               end else begin
                  hdr_count_in = hdr_count_ff + 4'd1;
               end
            end
            PH_LINE_SKIP: begin
               push      = 1'b1;
               cmd.kind  = CMD_LINE_SKIP;
               cmd.value = {8'h00, data_byte};
               phase_in  = PH_CODE;
            end
            PH_EXTRA_SKIP: begin
               push      = 1'b1;
               cmd.kind  = CMD_EXTRA_SKIP;
               cmd.value = {8'h00, data_byte};
               phase_in  = PH_CODE;
            end
            PH_CODE: begin
               if (data_byte == SKIP_AGAIN_CODE) begin
                  phase_in = PH_EXTRA_SKIP;
               end else if (data_byte == END_LINE_CODE) begin
                  push     = 1'b1;
                  cmd.kind = CMD_END_LINE;
                  lines_in = lines_dec;
                  phase_in = (lines_dec == 16'd0) ? PH_IDLE : PH_LINE_SKIP;
               end else begin
                  // A fill code of 0x80 gives 128, which still fits the run counter.
                  fill_in      = data_byte[7];
                  run_in       = data_byte[7] ? (8'd0 - data_byte) : data_byte;
                  color_idx_in = 2'd0;
                  color_in     = 24'd0;
                  phase_in     = PH_COLOR;
               end
            end
            PH_COLOR: begin
               color_in = color_shift;
               if (color_next_idx >= color_need) begin
                  produced     = 1'b1;
                  push         = 1'b1;
                  cmd.kind     = CMD_PIXEL;
                  cmd.value    = {8'h00, (fill_ff ? run_ff : 8'd1)};
                  cmd.color    = color_shift;
                  color_idx_in = 2'd0;
                  if (fill_ff) begin
                     run_in   = 8'd0;
                     phase_in = PH_CODE;
                  end else begin
                     run_in   = run_ff - 8'd1;
                     phase_in = (run_ff == 8'd1) ? PH_CODE : PH_COLOR;
                  end
               end else begin
                  color_idx_in = color_next_idx[1:0];
               end
            end
            PH_IDLE: begin
            end
            default: begin
               phase_in = PH_HEADER;
            end
         endcase

         if (packet_end) begin
            // The final byte always gives a result; all packet state starts over.
            push     = 1'b1;
            cmd.last = 1'b1;
            if (!produced) begin
               cmd.kind  = CMD_FRAME_END;
               cmd.value = 16'd0;
               cmd.color = 24'd0;
            end
            phase_in      = PH_HEADER;
            hdr_count_in  = 4'd0;
            range_in      = 1'b0;
            first_line_in = 16'd0;
            lines_in      = 16'd0;
            run_in        = 8'd0;
            fill_in       = 1'b0;
            color_idx_in  = 2'd0;
            color_in      = 24'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         hdr_count_ff  <= 4'd0;
         range_ff      <= 1'b0;
         first_line_ff <= 16'd0;
         lines_ff      <= 16'd0;
         run_ff        <= 8'd0;
         fill_ff       <= 1'b0;
         color_idx_ff  <= 2'd0;
         color_ff      <= 24'd0;
      end else begin
         phase_ff      <= phase_in;
         hdr_count_ff  <= hdr_count_in;
         range_ff      <= range_in;
         first_line_ff <= first_line_in;
         lines_ff      <= lines_in;
         run_ff        <= run_in;
         fill_ff       <= fill_in;
         color_idx_ff  <= color_idx_in;
         color_ff      <= color_in;
      end
   end

endmodule

[rtl/core/arle_queue.sv]
// Short command queue between the parser and the address unit.
module arle_queue import arle_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    can_push,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign can_push   = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_cmd;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> can_push)
      else $error("command pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("command popped from an empty queue");

endmodule

[rtl/core/arle_back.sv]
// Address unit: tracks row and pixel addresses and forms frame-buffer writes.
module arle_back import arle_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              head_valid,
   input  cmd_type           head_cmd,
   output logic              pop,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [ADDR_W-1:0] rsp_address,
   output logic [7:0]        rsp_length,
   output logic [7:0]        rsp_blue,
   output logic [7:0]        rsp_green,
   output logic [7:0]        rsp_red,
   output logic              rsp_last
);

   logic [ADDR_W-1:0] row_base_ff, row_base_in;
   logic [ADDR_W-1:0] pix_addr_ff, pix_addr_in;
   logic              out_valid_ff, out_valid_in;
   logic [ADDR_W-1:0] out_addr_ff, out_addr_in;
   logic [7:0]        out_len_ff, out_len_in;
   logic [23:0]       out_color_ff, out_color_in;
   logic              out_last_ff, out_last_in;

   logic              produce, out_free;
   logic [2:0]        stride;
   logic [9:0]        scaled;      // low value byte times the stride
   logic [30:0]       start_prod;
   logic [ADDR_W-1:0] skip_delta;

   assign stride     = cfg.stride4 ? 3'd4 : 3'd3;
   assign scaled     = cfg.stride4 ? {head_cmd.value[7:0], 2'b00}
                                   : {1'b0, head_cmd.value[7:0], 1'b0}
                                     + {2'b00, head_cmd.value[7:0]};
   assign start_prod = 31'(head_cmd.value) * 31'(cfg.row_step);
   // A skip byte s moves (s - 1) pixels; s of zero steps back one pixel.
   assign skip_delta = ADDR_W'(scaled) - ADDR_W'(stride);

   assign produce  = (head_cmd.kind == CMD_PIXEL) || head_cmd.last;
   assign out_free = !out_valid_ff || rsp_ready;
   assign pop      = head_valid && (!produce || out_free);

   always_comb begin
      row_base_in  = row_base_ff;
      pix_addr_in  = pix_addr_ff;
      out_valid_in = out_free ? 1'b0 : out_valid_ff;
      out_addr_in  = out_addr_ff;
      out_len_in   = out_len_ff;
      out_color_in = out_color_ff;
      out_last_in  = out_last_ff;

      if (pop) begin
         case (head_cmd.kind)
            CMD_START:      row_base_in = start_prod[ADDR_W-1:0];
            CMD_LINE_SKIP:  pix_addr_in = row_base_ff + skip_delta;
            CMD_EXTRA_SKIP: pix_addr_in = pix_addr_ff + skip_delta;
            CMD_END_LINE:   row_base_in = row_base_ff + ADDR_W'(cfg.row_step);
            CMD_PIXEL:      pix_addr_in = pix_addr_ff + ADDR_W'(scaled);
            CMD_FRAME_END: begin
            end
            default: begin
            end
         endcase

         if (produce) begin
            out_valid_in = 1'b1;
            out_last_in  = head_cmd.last;
            if (head_cmd.kind == CMD_PIXEL) begin
               out_addr_in  = pix_addr_ff;
               out_len_in   = head_cmd.value[7:0];
               out_color_in = head_cmd.color;
            end else begin
               out_addr_in  = '0;
               out_len_in   = 8'd0;
               out_color_in = 24'd0;
            end
         end

         if (head_cmd.last) begin
            row_base_in = '0;
            pix_addr_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_base_ff  <= '0;
         pix_addr_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         row_base_ff  <= row_base_in;
         pix_addr_ff  <= pix_addr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_addr_ff  <= out_addr_in;
      out_len_ff   <= out_len_in;
      out_color_ff <= out_color_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_address = out_addr_ff;
   assign rsp_length  = out_len_ff;
   assign rsp_red     = out_color_ff[23:16];
   assign rsp_green   = out_color_ff[15:8];
   assign rsp_blue    = out_color_ff[7:0];
   assign rsp_last    = out_last_ff;

   a_empty_is_frame_end: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_len_ff == 8'd0) |-> (out_last_ff && out_addr_ff == '0))
      else $error("empty write that is not a frame end");

   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      (pop && head_cmd.last) |=> (row_base_ff == '0 && pix_addr_ff == '0))
      else $error("addresses not cleared after frame end");

endmodule

[rtl/core/animation_rle_frame_decoder.sv]
// Top level of the animation-RLE frame decoder: configuration, parser, queue, address unit.
// Throughput: one packet byte per cycle, sustained, while results are taken as offered.
// The byte that completes a write enters the command queue at its accepting edge;
// the write then moves from the queue into the output register, where rsp_ can take it.
// The four-entry queue lets the parser keep taking bytes while rsp_ stalls, until it fills.
// Reset (synchronous, active high) restores the default configuration and starts a new packet.
module animation_rle_frame_decoder import arle_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // Encoded packet bytes.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // packet_end
   // Frame-buffer writes.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [29:0] byte_address, [37:30] run_length,
                                    // [45:38] blue, [53:46] green, [61:54] red, zero above
   output logic        rsp_tlast,   // frame_end
   // Configuration writes.
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // Configuration registers. Change them only between packets; the block does not enforce it.
   logic        argb_ff;
   logic [12:0] width_ff;
   logic [15:0] height_ff;
   logic [2:0]  bpp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         argb_ff   <= 1'b0;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         bpp_ff    <= BPP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SOURCE_IS_ARGB:      argb_ff   <= csr_wdata[0];
            CSR_FRAME_WIDTH:         width_ff  <= csr_wdata[12:0];
            CSR_FRAME_HEIGHT:        height_ff <= csr_wdata;
            CSR_OUT_BYTES_PER_PIXEL: bpp_ff    <= csr_wdata[2:0];
            default: begin
            end
         endcase
      end
   end

   // Any stride other than four bytes acts as three. The row pitch uses the
   // width clamped to the largest supported row, times the stride.
   logic [12:0] width_clamped;
   cfg_type     cfg;

   assign width_clamped = (width_ff > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : width_ff;

   always_comb begin
      cfg.argb     = argb_ff;
      cfg.height   = height_ff;
      cfg.stride4  = (bpp_ff == BPP_FOUR);
      cfg.row_step = cfg.stride4 ? {width_clamped, 2'b00}
                                 : {1'b0, width_clamped, 1'b0} + {2'b00, width_clamped};
   end

   // Parser: one byte per accepted item, at most one command per byte.
   logic    accept;
   logic    push;
   cmd_type push_cmd;
   logic    can_push;

   assign req_tready = can_push;
   assign accept     = req_tvalid && req_tready;

   arle_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .accept     (accept),
      .data_byte  (req_tdata),
      .packet_end (req_tlast),
      .push       (push),
      .cmd        (push_cmd)
   );

   // The queue decouples the parser from result back-pressure.
   logic    pop;
   logic    head_valid;
   cmd_type head_cmd;

   arle_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .can_push   (can_push),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // Address unit: one command per cycle unless rsp_ back-pressure holds its output register, where results are held.
   logic [ADDR_W-1:0] rsp_address;
   logic [7:0]        rsp_length;
   logic [7:0]        rsp_blue;
   logic [7:0]        rsp_green;
   logic [7:0]        rsp_red;

   arle_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .head_valid  (head_valid),
      .head_cmd    (head_cmd),
      .pop         (pop),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_address (rsp_address),
      .rsp_length  (rsp_length),
      .rsp_blue    (rsp_blue),
      .rsp_green   (rsp_green),
      .rsp_red     (rsp_red),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, rsp_red, rsp_green, rsp_blue, rsp_length, rsp_address};

endmodule
